[src/scd_pkg.sv]
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types, constants and segment tables of the serial digit sign
// controller.
// ----------------------------------------------------------------------------
package scd_pkg;

  // default number of stored digits
  localparam int SCD_MAX_DIGITS = 4;

  // fixed run lengths
  localparam int MSG_BYTES = 4;
  localparam int FULL_RUN  = 8;

  // character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_F    = 8'h46;

  // action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // chain codes
  localparam logic CHAIN_DIGIT = 1'b0;
  localparam logic CHAIN_MSG   = 1'b1;

  // decoded kind of an input beat
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_DIGIT,
    KIND_TICK,
    KIND_DASH,
    KIND_FULL
  } scd_kind_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load;
  } scd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic last_step;
    logic out_free;
  } scd_sts_t;

  // seven-segment code of one decimal digit
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hEE;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'hBA;
      4'd3:    code = 8'h3E;
      4'd4:    code = 8'h56;
      4'd5:    code = 8'h7C;
      4'd6:    code = 8'hFC;
      4'd7:    code = 8'h0E;
      4'd8:    code = 8'hFE;
      4'd9:    code = 8'h7E;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // segment bytes of the word FULL
  function automatic logic [7:0] full_word(input logic [1:0] idx);
    logic [7:0] code;
    unique case (idx)
      2'd0:    code = 8'hE0;
      2'd1:    code = 8'hE0;
      2'd2:    code = 8'hE6;
      default: code = 8'hD8;
    endcase
    return code;
  endfunction

endpackage

[src/serial_digit_sign_controller_top.sv]
// ----------------------------------------------------------------------------
// serial_digit_sign_controller_top
// Digit sign controller: stores received digits and emits segment bytes
// and lamp levels on dash, F and blink tick beats.
// ----------------------------------------------------------------------------
//  channel   direction  tuser                          tdata
//  in_       slave      [0] action                     [7:0] char_code
//  out_      master     [0] byte_valid [1] chain_sel   [7:0] seg_byte [8] latch_after
//                                                      [9] green [10] red [11] status
//  out_tlast carries last_of_run
//
//  a digit or an ignored character emits no bytes; a tick emits one beat with
//  no valid byte; a dash emits 4 + MAX_DIGITS bytes and an F 8 bytes, one byte
//  per cycle into the single output register while out_tready is high.
//  rst_n is synchronous; the digit store is not cleared by reset.
//  in_tready is low while a run is being emitted.
// ----------------------------------------------------------------------------
module serial_digit_sign_controller_top import scd_pkg::*; #(
  parameter int MAX_DIGITS = SCD_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // [0] action
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] chain_select
  output logic [15:0] out_tdata,  // [7:0] seg_byte, [8] latch_after, [9] green_light,
                                  // [10] red_light, [11] status_light
  output logic        out_tlast   // last_of_run
);

  localparam int RUN_MAX = (MSG_BYTES + MAX_DIGITS > FULL_RUN) ?
                           (MSG_BYTES + MAX_DIGITS) : FULL_RUN;
  localparam int STEP_W  = $clog2(RUN_MAX);

  scd_cmd_t          cmd;
  scd_sts_t          sts;
  logic [STEP_W-1:0] step;

  // controller
  scd_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .step      (step)
  );

  // datapath
  scd_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser[0]),
    .in_char    (in_tdata),
    .cmd        (cmd),
    .step       (step),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[src/scd_ctrl.sv]
// ----------------------------------------------------------------------------
// scd_ctrl
// Controller: accepts input beats and steps through the bytes of a run.
// ----------------------------------------------------------------------------
module scd_ctrl import scd_pkg::*; #(
  parameter int MAX_DIGITS = SCD_MAX_DIGITS,
  localparam int RUN_MAX   = (MSG_BYTES + MAX_DIGITS > FULL_RUN) ?
                             (MSG_BYTES + MAX_DIGITS) : FULL_RUN,
  localparam int STEP_W    = $clog2(RUN_MAX)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  scd_sts_t          sts,
  output scd_cmd_t          cmd,
  output logic [STEP_W-1:0] step
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (sts.has_result) begin
            state_nxt = ST_RUN;
            step_nxt  = '0;
          end
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.last_step) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign step = step_r;

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> 32'(step_r) < RUN_MAX)
    else $error("step counter beyond longest run");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && sts.last_step |=> state_r == ST_IDLE)
    else $error("run did not end after its last byte");

  a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.capture && state_r == ST_RUN)
    else $error("byte loaded outside a run");
`endif

endmodule

[src/scd_datapath.sv]
// ----------------------------------------------------------------------------
// scd_datapath
// Datapath: digit store, lamp levels, byte generation and output register.
// ----------------------------------------------------------------------------
module scd_datapath import scd_pkg::*; #(
  parameter int MAX_DIGITS = SCD_MAX_DIGITS,
  localparam int RUN_MAX   = (MSG_BYTES + MAX_DIGITS > FULL_RUN) ?
                             (MSG_BYTES + MAX_DIGITS) : FULL_RUN,
  localparam int STEP_W    = $clog2(RUN_MAX),
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1),
  localparam int IDX_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1,
  localparam int CW        = STEP_W + CNT_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_action,
  input  logic [7:0]        in_char,
  input  scd_cmd_t          cmd,
  input  logic [STEP_W-1:0] step,
  output scd_sts_t          sts,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_tuser,
  output logic [15:0]       out_tdata,
  output logic              out_tlast
);

  logic [3:0]       digit_store_r [MAX_DIGITS];
  logic [CNT_W-1:0] digit_count_r, snap_cnt_r;
  scd_kind_t        kind_r, in_kind;
  logic             blink_r, green_r, red_r, status_r;

  logic             out_valid_r;
  logic             out_chain_r, out_bv_r, out_latch_r, out_last_r;
  logic [7:0]       out_byte_r;
  logic             out_green_r, out_red_r, out_status_r;

  logic             bv, chain, latch, last;
  logic [7:0]       seg;
  logic [CW-1:0]    step_ext, pos;
  logic [IDX_W-1:0] rd_idx;

  // input decode
  always_comb begin
    if (in_action == ACT_TICK) begin
      in_kind = KIND_TICK;
    end else if (in_char >= CHAR_ZERO && in_char <= CHAR_NINE) begin
      in_kind = KIND_DIGIT;
    end else if (in_char == CHAR_DASH) begin
      in_kind = KIND_DASH;
    end else if (in_char == CHAR_F) begin
      in_kind = KIND_FULL;
    end else begin
      in_kind = KIND_NONE;
    end
  end

  // digit store, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture && in_kind == KIND_DIGIT && 32'(digit_count_r) < MAX_DIGITS) begin
      digit_store_r[digit_count_r[IDX_W-1:0]] <= in_char[3:0];
    end
  end

  // count, lamps and run kind
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= '0;
      snap_cnt_r    <= '0;
      kind_r        <= KIND_NONE;
      blink_r       <= 1'b0;
      green_r       <= 1'b0;
      red_r         <= 1'b0;
      status_r      <= 1'b1;
    end else if (cmd.capture) begin
      kind_r     <= in_kind;
      snap_cnt_r <= digit_count_r;
      unique case (in_kind)
        KIND_DIGIT: begin
          if (32'(digit_count_r) < MAX_DIGITS) begin
            digit_count_r <= digit_count_r + 1'b1;
          end
        end
        KIND_TICK: begin
          status_r <= ~status_r;
          green_r  <= green_r ^ blink_r;
        end
        KIND_DASH: begin
          digit_count_r <= '0;
          blink_r       <= 1'b1;
          green_r       <= 1'b1;
          red_r         <= 1'b0;
        end
        KIND_FULL: begin
          digit_count_r <= '0;
          blink_r       <= 1'b0;
          green_r       <= 1'b0;
          red_r         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // digit read position, newest first
  assign step_ext = CW'(step);
  assign pos      = CW'(snap_cnt_r) - CW'(1) - (step_ext - CW'(MSG_BYTES));
  assign rd_idx   = pos[IDX_W-1:0];

  // byte of the current step
  always_comb begin
    bv    = 1'b1;
    chain = CHAIN_DIGIT;
    seg   = 8'h00;
    latch = 1'b0;
    last  = 1'b0;
    unique case (kind_r)
      KIND_TICK: begin
        bv   = 1'b0;
        last = 1'b1;
      end
      KIND_DASH: begin
        if (step_ext < CW'(MSG_BYTES)) begin
          chain = CHAIN_MSG;
          latch = (step_ext == CW'(MSG_BYTES - 1));
        end else begin
          if (step_ext - CW'(MSG_BYTES) < CW'(snap_cnt_r)) begin
            seg = seg_code(digit_store_r[rd_idx]);
          end
          latch = (step_ext == CW'(MSG_BYTES + MAX_DIGITS - 1));
          last  = latch;
        end
      end
      KIND_FULL: begin
        if (step_ext < CW'(MSG_BYTES)) begin
          latch = (step_ext == CW'(MSG_BYTES - 1));
        end else begin
          chain = CHAIN_MSG;
          seg   = full_word(step_ext[1:0]);
          latch = (step_ext == CW'(FULL_RUN - 1));
          last  = latch;
        end
      end
      default: begin
        bv   = 1'b0;
        last = 1'b1;
      end
    endcase
  end

  assign sts.has_result = (in_kind == KIND_TICK) || (in_kind == KIND_DASH) ||
                          (in_kind == KIND_FULL);
  assign sts.last_step  = last;
  assign sts.out_free   = !out_valid_r || out_tready;

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_bv_r     <= bv;
      out_chain_r  <= chain;
      out_byte_r   <= seg;
      out_latch_r  <= latch;
      out_last_r   <= last;
      out_green_r  <= green_r;
      out_red_r    <= red_r;
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_chain_r, out_bv_r};
  assign out_tdata  = {4'b0000, out_status_r, out_red_r, out_green_r, out_latch_r,
                       out_byte_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(digit_count_r) <= MAX_DIGITS)
    else $error("digit count above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("output beat overwritten");

  a_tick_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && in_kind == KIND_TICK |=> status_r != $past(status_r))
    else $error("status lamp did not toggle on tick");
`endif

endmodule
